[rtl/core/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies; each macro takes a label, clock, active-low reset and property parts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/skf_pkg.sv]
// shared types, constants and microcode table of the scalar kalman filter
// no dependencies
`default_nettype none

package skf_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int GUARD_FRAC_BITS_DEF = 16;

  localparam int COV_W  = 24;
  localparam int GAIN_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COV_W-1:0]  COV_MAX   = 24'hFFFFFF;
  localparam logic [COV_W-1:0]  COV_RESET = 24'd1311;
  localparam logic [COV_W-1:0]  Q_RESET   = 24'd655;
  localparam logic [COV_W-1:0]  R_RESET   = 24'd16384;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_MUL_P    = 4'd1;
  localparam step_t STEP_WAIT_MP  = 4'd2;
  localparam step_t STEP_UPD_P    = 4'd3;
  localparam step_t STEP_DIV      = 4'd4;
  localparam step_t STEP_WAIT_DIV = 4'd5;
  localparam step_t STEP_UPD_K    = 4'd6;
  localparam step_t STEP_MUL_E    = 4'd7;
  localparam step_t STEP_WAIT_ME  = 4'd8;
  localparam step_t STEP_UPD_E    = 4'd9;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_MUL_P,
    ACT_UPD_P,
    ACT_DIV,
    ACT_UPD_K,
    ACT_MUL_E,
    ACT_UPD_E
  } act_e;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN,
    CND_MUL,
    CND_DIV,
    CND_OUT
  } cnd_e;

  typedef struct packed {
    act_e  act;
    cnd_e  cnd;
    step_t jump;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic mul_busy;
    logic div_busy;
    logic out_full;
  } seq_status_t;

  typedef struct packed {
    act_e act;
    logic fire;
    logic idle;
  } seq_ctrl_t;

  // program: the step waits until its condition holds, then acts and jumps
  function automatic uword_t urom(step_t s);
    uword_t w;
    unique case (s)
      STEP_IDLE:     w = '{act: ACT_LATCH, cnd: CND_IN,     jump: STEP_MUL_P};
      STEP_MUL_P:    w = '{act: ACT_MUL_P, cnd: CND_ALWAYS, jump: STEP_WAIT_MP};
      STEP_WAIT_MP:  w = '{act: ACT_NONE,  cnd: CND_MUL,    jump: STEP_UPD_P};
      STEP_UPD_P:    w = '{act: ACT_UPD_P, cnd: CND_ALWAYS, jump: STEP_DIV};
      STEP_DIV:      w = '{act: ACT_DIV,   cnd: CND_ALWAYS, jump: STEP_WAIT_DIV};
      STEP_WAIT_DIV: w = '{act: ACT_NONE,  cnd: CND_DIV,    jump: STEP_UPD_K};
      STEP_UPD_K:    w = '{act: ACT_UPD_K, cnd: CND_ALWAYS, jump: STEP_MUL_E};
      STEP_MUL_E:    w = '{act: ACT_MUL_E, cnd: CND_ALWAYS, jump: STEP_WAIT_ME};
      STEP_WAIT_ME:  w = '{act: ACT_NONE,  cnd: CND_MUL,    jump: STEP_UPD_E};
      STEP_UPD_E:    w = '{act: ACT_UPD_E, cnd: CND_OUT,    jump: STEP_IDLE};
      default:       w = '{act: ACT_NONE,  cnd: CND_ALWAYS, jump: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/skf_mul.sv]
// shift-add multiplier: unsigned gain-width operand times signed operand, one bit per cycle
// depends on skf_pkg
`default_nettype none

module skf_mul #(
  parameter int BW = 25
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic        [skf_pkg::GAIN_W-1:0]     a_i,
  input  wire logic signed [BW-1:0]                  b_i,
  output logic                                       busy_o,
  output logic signed      [BW+skf_pkg::GAIN_W-1:0]  prod_o
);

  localparam int AW   = skf_pkg::GAIN_W;
  localparam int PW   = BW + AW;
  localparam int CntW = $clog2(AW + 1);

  logic [CntW-1:0]        cnt_q;
  logic [AW-1:0]          a_q;
  logic signed [BW-1:0]   b_q;
  logic signed [PW-1:0]   acc_q;
  logic signed [PW-1:0]   addend;

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;
  assign addend = a_q[AW-1] ? PW'(b_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(AW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // msb first: double the partial sum and add the multiplicand where the bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_o) begin
      acc_q <= (acc_q <<< 1) + addend;
      a_q   <= a_q << 1;
    end
  end

endmodule

`default_nettype wire

[rtl/core/skf_div.sv]
// restoring divider for the gain: quotient of (num << 16) by den, one bit per cycle
// depends on skf_pkg; valid for num <= den
`default_nettype none

module skf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [skf_pkg::COV_W-1:0]     num_i,
  input  wire logic [skf_pkg::COV_W:0]       den_i,
  output logic                               busy_o,
  output logic      [skf_pkg::GAIN_W-1:0]    quot_o
);

  localparam int CW   = skf_pkg::COV_W;
  localparam int QW   = skf_pkg::GAIN_W;
  localparam int CntW = $clog2(QW + 1);

  logic [CntW-1:0] cnt_q;
  logic [CW:0]     rem_q;
  logic [CW:0]     den_q;
  logic [QW-1:0]   nb_q;
  logic [QW-1:0]   quot_q;
  logic [CW+1:0]   trial;
  logic [CW+1:0]   trial_sub;
  logic            ge;

  assign busy_o    = (cnt_q != '0);
  assign quot_o    = quot_q;
  assign trial     = {rem_q, nb_q[QW-1]};
  assign ge        = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(QW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // the top bits of the shifted numerator start in the remainder, the rest feed in serially
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= (CW+1)'(num_i[CW-1:1]);
      nb_q   <= {num_i[0], {(QW-1){1'b0}}};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_o) begin
      rem_q  <= ge ? trial_sub[CW:0] : trial[CW:0];
      nb_q   <= nb_q << 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[rtl/core/skf_seq.sv]
// microcode sequencer: step counter over the program table with conditional jumps
// depends on skf_pkg
`default_nettype none

module skf_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire skf_pkg::seq_status_t status_i,
  output skf_pkg::seq_ctrl_t        ctrl_o
);

  skf_pkg::step_t  step_q, step_d;
  skf_pkg::uword_t uw;
  logic            cond_met;

  assign uw = skf_pkg::urom(step_q);

  always_comb begin
    unique case (uw.cnd)
      skf_pkg::CND_ALWAYS: cond_met = 1'b1;
      skf_pkg::CND_IN:     cond_met = status_i.in_valid;
      skf_pkg::CND_MUL:    cond_met = !status_i.mul_busy;
      skf_pkg::CND_DIV:    cond_met = !status_i.div_busy;
      skf_pkg::CND_OUT:    cond_met = !status_i.out_full;
      default:             cond_met = 1'b0;
    endcase
  end

  assign step_d = cond_met ? uw.jump : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= skf_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.act  = uw.act;
  assign ctrl_o.fire = cond_met;
  assign ctrl_o.idle = (step_q == skf_pkg::STEP_IDLE);

endmodule

`default_nettype wire

[rtl/core/scalar_kalman_filter_unit.sv]
// top level of the scalar kalman filter: datapath registers, config registers, output register
// depends on skf_pkg, skf_seq, skf_mul, skf_div
//
//  channel   signals                                     direction
//  input     in_valid_i, in_stall_o, sample_i            in
//  output    out_valid_o, out_stall_i, estimate_o, gain_o out
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,      in
//            cfg_data_i
//
// a sample is worked on from acceptance until its result is written to the output register, and the
// next sample can be taken the cycle after; no new sample is taken while one is worked on. The work is
// three passes through the serial units (two multiplies and the gain division) plus the program steps.
// reset sets covariance, gain and estimate at once; there is no clearing pass.
// a result waits in the output register while stalled; the next sample is still accepted
// and worked on, and only its final write step waits for the register to drain.
`default_nettype none

module scalar_kalman_filter_unit #(
  parameter int SAMPLE_WIDTH    = skf_pkg::SAMPLE_WIDTH_DEF,
  parameter int GUARD_FRAC_BITS = skf_pkg::GUARD_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [SAMPLE_WIDTH-1:0]       estimate_o,
  output logic             [skf_pkg::GAIN_W-1:0]    gain_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [skf_pkg::COV_W-1:0]     cfg_data_i
);

  localparam int CW    = skf_pkg::COV_W;
  localparam int GW    = skf_pkg::GAIN_W;
  localparam int EstW  = SAMPLE_WIDTH + GUARD_FRAC_BITS;
  localparam int DiffW = EstW + 1;
  localparam int MulBw = (DiffW > CW + 1) ? DiffW : CW + 1;
  localparam int ProdW = MulBw + GW;

  skf_pkg::seq_status_t status;
  skf_pkg::seq_ctrl_t   ctrl;

  logic [CW-1:0]               q_q;
  logic [CW-1:0]               r_q;
  logic [CW-1:0]               plast_q;
  logic [GW-1:0]               k_q;
  logic signed [EstW-1:0]      est_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                        out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] estimate_q;
  logic [GW-1:0]               gain_q;

  logic                        mul_start;
  logic [GW-1:0]               mul_a;
  logic signed [MulBw-1:0]     mul_b;
  logic                        mul_busy;
  logic signed [ProdW-1:0]     prod;
  logic                        div_start;
  logic                        div_busy;
  logic [GW-1:0]               quot;

  logic [CW:0]                 den;
  logic [CW+1:0]               p_sum;
  logic [CW-1:0]               p_sat;
  logic [GW-1:0]               k_new;
  logic signed [DiffW-1:0]     x_ext;
  logic signed [DiffW-1:0]     diff;
  logic signed [EstW-1:0]      est_d;

  assign status.in_valid = in_valid_i;
  assign status.mul_busy = mul_busy;
  assign status.div_busy = div_busy;
  assign status.out_full = out_valid_q && out_stall_i;

  skf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_stall_o = !ctrl.idle;
  assign cfg_ready_o = 1'b1;

  // covariance update: ((1 - K) * Plast >> 16) + Q, saturated
  assign p_sum = (CW+2)'(prod[CW+16:16]) + (CW+2)'(q_q);
  assign p_sat = (p_sum > (CW+2)'(skf_pkg::COV_MAX)) ? skf_pkg::COV_MAX : p_sum[CW-1:0];
  assign den   = (CW+1)'(plast_q) + (CW+1)'(r_q);

  // gain is zero when P + R is zero
  always_comb begin
    if (den == '0) begin
      k_new = '0;
    end else if (quot > skf_pkg::GAIN_ONE) begin
      k_new = skf_pkg::GAIN_ONE;
    end else begin
      k_new = quot;
    end
  end

  assign x_ext = DiffW'(sample_q) <<< GUARD_FRAC_BITS;
  assign diff  = x_ext - DiffW'(est_q);
  assign est_d = est_q + prod[EstW+15:16];

  assign mul_start = ctrl.fire &&
                     (ctrl.act == skf_pkg::ACT_MUL_P || ctrl.act == skf_pkg::ACT_MUL_E);
  assign mul_a     = (ctrl.act == skf_pkg::ACT_MUL_P) ? (skf_pkg::GAIN_ONE - k_q) : k_q;
  assign mul_b     = (ctrl.act == skf_pkg::ACT_MUL_P) ? MulBw'($signed({1'b0, plast_q}))
                                                       : MulBw'(diff);
  assign div_start = ctrl.fire && (ctrl.act == skf_pkg::ACT_DIV);

  skf_mul #(
    .BW (MulBw)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (plast_q),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= skf_pkg::Q_RESET;
      r_q <= skf_pkg::R_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        skf_pkg::CFG_PROCESS_NOISE:     q_q <= cfg_data_i;
        skf_pkg::CFG_MEASUREMENT_NOISE: r_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plast_q <= skf_pkg::COV_RESET;
      k_q     <= '0;
      est_q   <= '0;
    end else if (ctrl.fire) begin
      unique case (ctrl.act)
        skf_pkg::ACT_UPD_P: plast_q <= p_sat;
        skf_pkg::ACT_UPD_K: k_q     <= k_new;
        skf_pkg::ACT_UPD_E: est_q   <= est_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire && ctrl.act == skf_pkg::ACT_LATCH) begin
      sample_q <= sample_i;
    end
  end

  // output register, loaded only once the previous transaction has drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fire && ctrl.act == skf_pkg::ACT_UPD_E) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire && ctrl.act == skf_pkg::ACT_UPD_E) begin
      estimate_q <= est_d[EstW-1:GUARD_FRAC_BITS];
      gain_q     <= k_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = estimate_q;
  assign gain_o      = gain_q;

endmodule

`default_nettype wire

[rtl/core/skf_chk.sv]
// port-level checker for the scalar kalman filter, attached by bind
// depends on skf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module skf_chk #(
  parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic signed [SAMPLE_WIDTH-1:0]       estimate_o,
  input wire logic        [skf_pkg::GAIN_W-1:0]    gain_o,
  input wire logic                                 cfg_valid_i,
  input wire logic                                 cfg_ready_o
);

  logic in_fire;

  assign in_fire = in_valid_i && !in_stall_o;

  // gain never exceeds one
  `ASSERT_IMPL(a_gain_range, clk_i, rst_ni, out_valid_o, gain_o <= skf_pkg::GAIN_ONE)

  // an accepted sample keeps the input side busy while it is worked on
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, in_stall_o)

  // a new result only appears at the end of a sample's work
  `ASSERT_IMPL(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(estimate_o) && $stable(gain_o))

  // config is taken in any cycle
  `ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind scalar_kalman_filter_unit skf_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_skf_chk (.*);

`default_nettype wire

[tb/sv/scalar_kalman_filter_unit_tb.sv]
// self-checking testbench for scalar_kalman_filter_unit: drives samples and noise settings,
// predicts estimate and gain in fixed point and compares every result transaction
// depends on skf_pkg and the scalar_kalman_filter_unit rtl
module scalar_kalman_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = skf_pkg::SAMPLE_WIDTH_DEF;
  localparam int GF = skf_pkg::GUARD_FRAC_BITS_DEF;
  localparam int IW = skf_pkg::CFG_IDX_W;
  localparam int CVW = skf_pkg::COV_W;
  localparam int GNW = skf_pkg::GAIN_W;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES = 150;

  // indexes the register file decodes to nothing
  localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] estimate;
    logic [GNW-1:0]       gain;
  } filter_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [SW-1:0] sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SW-1:0] estimate_o;
  logic [GNW-1:0]       gain_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [IW-1:0]        cfg_index_i = '0;
  logic [CVW-1:0]       cfg_data_i = '0;

  // filter state mirrored on the testbench side
  logic [CVW-1:0]          noise_q = skf_pkg::Q_RESET;
  logic [CVW-1:0]          noise_r = skf_pkg::R_RESET;
  logic [CVW-1:0]          kf_cov = skf_pkg::COV_RESET;
  logic [GNW-1:0]          kf_gain = '0;
  logic signed [SW+GF-1:0] kf_est_acc = '0;

  filter_out_t expected_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  scalar_kalman_filter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .estimate_o  (estimate_o),
    .gain_o      (gain_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 4);
    return $urandom_range(5, 140);
  endfunction

  function automatic logic [CVW-1:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return skf_pkg::COV_MAX;
      2:       return CVW'($urandom_range(1, 255));
      3:       return CVW'($urandom_range(256, 65535));
      default: return CVW'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // covariance, gain and estimate update for one accepted sample
  task automatic filter_update(input logic signed [SW-1:0] s);
    longint     cov_pred;
    longint     den;
    longint     k;
    longint     diff;
    longint     est;
    filter_out_t res;
    cov_pred = ((longint'(skf_pkg::GAIN_ONE) - longint'(kf_gain)) * longint'(kf_cov)) >>> 16;
    cov_pred += longint'(noise_q);
    if (cov_pred > longint'(skf_pkg::COV_MAX)) cov_pred = longint'(skf_pkg::COV_MAX);
    den = cov_pred + longint'(noise_r);
    if (den == 0) begin
      k = 0;
    end else begin
      k = (cov_pred <<< 16) / den;
      if (k > longint'(skf_pkg::GAIN_ONE)) k = longint'(skf_pkg::GAIN_ONE);
    end
    diff = (longint'(s) <<< GF) - longint'(kf_est_acc);
    // arithmetic shift of a longint is the floor of the product
    est = longint'(kf_est_acc) + ((k * diff) >>> 16);
    kf_est_acc = est[SW+GF-1:0];
    kf_gain = k[GNW-1:0];
    kf_cov = cov_pred[CVW-1:0];
    res.estimate = est[GF +: SW];
    res.gain = kf_gain;
    expected_results.push_back(res);
  endtask

  // valid stays high when the next sample follows with no gap
  task automatic send_sample(input logic signed [SW-1:0] s);
    int gap;
    in_valid_i <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    filter_update(s);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CVW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == skf_pkg::CFG_PROCESS_NOISE) noise_q = val;
    else if (idx == skf_pkg::CFG_MEASUREMENT_NOISE) noise_r = val;
  endtask

  task automatic set_noise(input logic [CVW-1:0] q, input logic [CVW-1:0] r);
    wait_drained();
    write_reg(skf_pkg::CFG_PROCESS_NOISE, q);
    write_reg(skf_pkg::CFG_MEASUREMENT_NOISE, r);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // receiver side: random stall bursts
  initial begin : out_stall_gen
    int hold;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    filter_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result estimate", 0, longint'(estimate_o));
      end else begin
        want = expected_results.pop_front();
        if (estimate_o !== want.estimate)
          flag_mismatch("estimate", longint'(want.estimate), longint'(estimate_o));
        if (gain_o !== want.gain)
          flag_mismatch("gain", longint'(want.gain), longint'(gain_o));
      end
    end
  end

  // reset noise settings with the sample extremes and alternating bit patterns
  task automatic test_default_noise();
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
  endtask

  // q = r = 0 drives the gain to one and then leaves a zero denominator; q = 1, r = 0 drives the gain to one
  task automatic test_zero_noise();
    set_noise('0, '0);
    send_sample(16'sh1234);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh0100);
    send_sample(16'sh0003);
    set_noise(24'd1, '0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0A5A);
  endtask

  task automatic test_noise_saturation();
    set_noise(skf_pkg::COV_MAX, skf_pkg::COV_MAX);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh4000);
  endtask

  // writes to undecoded indexes must leave q and r alone
  task automatic test_unmapped_index();
    wait_drained();
    write_reg(CFG_SPARE_A, CVW'($urandom_range(0, 24'hFFFFFF)));
    write_reg(CFG_SPARE_B, CVW'($urandom_range(0, 24'hFFFFFF)));
    cfg_valid_i <= 1'b0;
    send_sample(16'sh2000);
    send_sample(-16'sh2000);
  endtask

  task automatic test_drain_pause();
    set_noise(skf_pkg::Q_RESET, skf_pkg::R_RESET);
    repeat (3) begin
      send_sample(SW'($urandom_range(0, 65535)));
      wait_drained();
    end
  endtask

  // drifting levels with noise, some steps, a quarter of plain random samples
  task automatic test_random_traffic();
    int level;
    int s;
    level = 0;
    for (int phase = 0; phase < 8; phase++) begin
      set_noise(pick_noise(), pick_noise());
      quiet = (phase % 3 == 2);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 19) == 0) level = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 3) == 0) s = int'($urandom_range(0, 65535)) - 32768;
        else s = level + int'($urandom_range(0, 127)) - 64;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        send_sample(s[SW-1:0]);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_noise();
    test_zero_noise();
    test_noise_saturation();
    test_unmapped_index();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
